/* hw/rtl/hte_pkg.sv */
package hte_pkg;

   // longest tag prefix kept
   localparam int unsigned TAG_PREFIX_LEN = 8;
   localparam int unsigned TAG_LEN_W      = $clog2(TAG_PREFIX_LEN + 1);
   localparam int unsigned TAG_IDX_W      = $clog2(TAG_PREFIX_LEN);

   // front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;

   // entity patterns, in replace-pass order
   localparam int unsigned NUM_ENT = 5;
   localparam int unsigned ENT_AMP = 3;
   localparam int unsigned ENT_QUOT = 4;
   localparam logic [7:0] ENT_PAT [NUM_ENT][6] = '{
      '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},   // &nbsp;
      '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
      '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
      '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
      '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}    // &quot;
   };
   localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd6, 3'd4, 3'd4, 3'd5, 3'd6};
   localparam logic [7:0] ENT_REP [NUM_ENT] = '{8'h20, 8'h3C, 8'h3E, 8'h26, 8'h22};

   // list item: newline, space, bullet, space
   localparam logic [2:0] LI_LEN = 3'd6;
   localparam logic [7:0] LI_SEQ [6] = '{8'h0A, 8'h20, 8'hE2, 8'h80, 8'hA2, 8'h20};

   typedef enum logic [1:0] {
      JOB_NONE,
      JOB_CHAR,
      JOB_NEWLINE,
      JOB_BULLET
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } job_type;

endpackage

/* hw/rtl/hte_if.sv */
interface hte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface hte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_empty;
   logic       run_last;
   logic       text_done;

   modport source (output valid, output out_byte, output out_empty, output run_last,
                   output text_done, input ready);
   modport sink   (input valid, input out_byte, input out_empty, input run_last,
                   input text_done, output ready);
endinterface

/* hw/rtl/hte_front.sv */
module hte_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_end,
   input  logic              job_ready,
   output logic              job_valid,
   output hte_pkg::job_type  job
);

   localparam int unsigned PW = hte_pkg::TAG_PREFIX_LEN * 8;

   logic                            tag_open_ff, tag_open_in;
   logic                            script_ff, script_in;
   logic                            style_ff, style_in;
   logic [PW-1:0]                   prefix_ff, prefix_in;
   logic [hte_pkg::TAG_LEN_W-1:0]   len_ff, len_in;
   logic                            ovf_ff, ovf_in;
   logic                            accept, eval, quiet;
   logic [7:0]                      low_c;

   // prefix test against a packed pattern of n bytes (first byte highest)
   function automatic logic tag_starts(input logic [PW-1:0] pfx,
                                       input logic [hte_pkg::TAG_LEN_W-1:0] len,
                                       input logic [55:0] pat, input int unsigned n);
      logic ok;
      ok = (len >= hte_pkg::TAG_LEN_W'(n));
      for (int unsigned i = 0; i < 7; i++) begin
         if (i < n && pfx[8*i +: 8] != pat[8*(n-1-i) +: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic tag_is(input logic [PW-1:0] pfx,
                                   input logic [hte_pkg::TAG_LEN_W-1:0] len,
                                   input logic ovf, input logic [55:0] pat,
                                   input int unsigned n);
      return !ovf && len == hte_pkg::TAG_LEN_W'(n) && tag_starts(pfx, len, pat, n);
   endfunction

   assign job_valid = in_valid;
   assign accept    = in_valid && job_ready;
   assign low_c     = (in_byte inside {[8'h41:8'h5A]}) ? in_byte + 8'h20 : in_byte;
   assign quiet     = script_ff || style_ff;

   always_comb begin
      tag_open_in = tag_open_ff;
      script_in   = script_ff;
      style_in    = style_ff;
      prefix_in   = prefix_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      job.kind    = hte_pkg::JOB_NONE;
      job.data    = in_byte;
      job.last    = in_end;

      if (tag_open_ff) begin
         if (in_byte == hte_pkg::CH_GT) begin
            tag_open_in = 1'b0;
         end else if (len_ff < hte_pkg::TAG_LEN_W'(hte_pkg::TAG_PREFIX_LEN)) begin
            prefix_in[8*len_ff[hte_pkg::TAG_IDX_W-1:0] +: 8] = low_c;
            len_in = len_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else if (in_byte == hte_pkg::CH_LT) begin
         tag_open_in = 1'b1;
         len_in      = '0;
         ovf_in      = 1'b0;
      end else if (!quiet) begin
         job.kind = hte_pkg::JOB_CHAR;
      end

      eval = (tag_open_ff && in_byte == hte_pkg::CH_GT) || (in_end && tag_open_in);
      if (eval) begin
         if (tag_starts(prefix_in, len_in, 56'("script"), 6)) begin
            script_in = 1'b1;
         end else if (tag_starts(prefix_in, len_in, 56'("/script"), 7)) begin
            script_in = 1'b0;
         end else if (tag_starts(prefix_in, len_in, 56'("style"), 5)) begin
            style_in = 1'b1;
         end else if (tag_starts(prefix_in, len_in, 56'("/style"), 6)) begin
            style_in = 1'b0;
         end else if (tag_is(prefix_in, len_in, ovf_in, 56'("p"), 1)
                   || tag_is(prefix_in, len_in, ovf_in, 56'("div"), 3)
                   || tag_is(prefix_in, len_in, ovf_in, 56'("br"), 2)
                   || tag_is(prefix_in, len_in, ovf_in, 56'("tr"), 2)
                   || tag_is(prefix_in, len_in, ovf_in, 56'("/h1"), 3)
                   || tag_is(prefix_in, len_in, ovf_in, 56'("/h2"), 3)
                   || tag_is(prefix_in, len_in, ovf_in, 56'("/h3"), 3)) begin
            if (!quiet) job.kind = hte_pkg::JOB_NEWLINE;
         end else if (tag_is(prefix_in, len_in, ovf_in, 56'("li"), 2)) begin
            if (!quiet) job.kind = hte_pkg::JOB_BULLET;
         end
         tag_open_in = 1'b0;
      end

      if (in_end) begin
         tag_open_in = 1'b0;
         script_in   = 1'b0;
         style_in    = 1'b0;
         len_in      = '0;
         ovf_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_open_ff <= 1'b0;
         script_ff   <= 1'b0;
         style_ff    <= 1'b0;
         len_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else if (accept) begin
         tag_open_ff <= tag_open_in;
         script_ff   <= script_in;
         style_ff    <= style_in;
         len_ff      <= len_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) prefix_ff <= prefix_in;
   end

endmodule

/* hw/rtl/hte_queue.sv */
module hte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hte_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop,
   output hte_pkg::job_type  pop_job
);

   hte_pkg::job_type                mem [hte_pkg::QUEUE_DEPTH];
   logic [hte_pkg::QUEUE_AW-1:0]    wr_ff, rd_ff;
   logic [hte_pkg::QUEUE_CW-1:0]    count_ff;
   logic                            do_push, do_pop;

   assign push_ready = count_ff != hte_pkg::QUEUE_CW'(hte_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = mem[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_job;
   end

endmodule

/* hw/rtl/hte_back.sv */
module hte_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  hte_pkg::job_type  job,
   output logic              job_pop,
   hte_rsp_if.source         rsp
);

   logic [7:0] hold_ff [5];
   logic [7:0] hold_in [5];
   logic [2:0] cnt_ff, cnt_in;
   logic       amp_ff, amp_in;
   logic       prev_nl_ff, prev_nl_in;
   logic [2:0] feed_ff, feed_in;
   logic       flush_ff, flush_in;
   logic [2:0] fl_ff, fl_in;

   logic       pend_v_ff, pend_empty_ff, pend_rl_ff, pend_td_ff;
   logic [7:0] pend_byte_ff;
   logic       rsp_v_ff, rsp_empty_ff, rsp_rl_ff, rsp_td_ff;
   logic [7:0] rsp_byte_ff;

   logic       out_free, step, in_flush, feeds_done, last, cand_v, emit;
   logic       push, push_empty, push_rl, push_td, move, set_flags, hit, ok;
   logic [7:0] cand, fbyte, push_byte;
   logic [2:0] nfeeds, n;
   logic [2:0] hit_k;

   assign out_free = !rsp_v_ff || rsp.ready;
   assign step     = job_valid && (out_free || !pend_v_ff);
   assign n        = cnt_ff + 3'd1;

   always_comb begin
      case (job.kind)
         hte_pkg::JOB_CHAR, hte_pkg::JOB_NEWLINE: nfeeds = 3'd1;
         hte_pkg::JOB_BULLET:                      nfeeds = hte_pkg::LI_LEN;
         default:                                  nfeeds = 3'd0;
      endcase
      case (job.kind)
         hte_pkg::JOB_CHAR:    fbyte = job.data;
         hte_pkg::JOB_NEWLINE: fbyte = hte_pkg::CH_LF;
         default:              fbyte = hte_pkg::LI_SEQ[feed_ff];
      endcase
   end

   assign feeds_done = feed_ff == nfeeds;
   assign in_flush   = flush_ff || (feeds_done && job.last && cnt_ff != '0);

   // first entity pattern that the held bytes plus this byte still follow
   always_comb begin
      hit   = 1'b0;
      hit_k = '0;
      for (int k = hte_pkg::NUM_ENT - 1; k >= 0; k--) begin
         ok = (!amp_ff || k == hte_pkg::ENT_QUOT) && n <= hte_pkg::ENT_LEN[k]
              && fbyte == hte_pkg::ENT_PAT[k][cnt_ff];
         for (int i = 0; i < 5; i++) begin
            if (3'(i) < cnt_ff && hold_ff[i] != hte_pkg::ENT_PAT[k][i]) ok = 1'b0;
         end
         if (ok) begin
            hit   = 1'b1;
            hit_k = 3'(k);
         end
      end
   end

   always_comb begin
      hold_in  = hold_ff;
      cnt_in   = cnt_ff;
      amp_in   = amp_ff;
      feed_in  = feed_ff;
      flush_in = flush_ff;
      fl_in    = fl_ff;
      cand_v   = 1'b0;
      cand     = fbyte;
      last     = 1'b0;

      if (in_flush) begin
         cand_v = 1'b1;
         cand   = hold_ff[fl_ff];
         if (fl_ff == cnt_ff - 3'd1) begin
            cnt_in   = '0;
            amp_in   = 1'b0;
            flush_in = 1'b0;
            fl_in    = '0;
            last     = feeds_done;
         end else begin
            fl_in = fl_ff + 3'd1;
         end
      end else if (!feeds_done) begin
         if (cnt_ff == '0) begin
            if (fbyte == hte_pkg::CH_AMP) begin
               hold_in[0] = hte_pkg::CH_AMP;
               cnt_in     = 3'd1;
               amp_in     = 1'b0;
            end else begin
               cand_v = 1'b1;
            end
            feed_in = feed_ff + 3'd1;
         end else if (hit) begin
            if (n == hte_pkg::ENT_LEN[hit_k]) begin
               if (hit_k == 3'(hte_pkg::ENT_AMP)) begin
                  hold_in[0] = hte_pkg::CH_AMP;
                  cnt_in     = 3'd1;
                  amp_in     = 1'b1;
               end else begin
                  cand_v = 1'b1;
                  cand   = hte_pkg::ENT_REP[hit_k];
                  cnt_in = '0;
                  amp_in = 1'b0;
               end
            end else begin
               hold_in[cnt_ff] = fbyte;
               cnt_in          = n;
            end
            feed_in = feed_ff + 3'd1;
         end else begin
            // mismatch: spill held bytes, then retry this byte
            flush_in = 1'b1;
            fl_in    = '0;
         end
         if (feed_in != feed_ff) begin
            last = (feed_in == nfeeds) && (!job.last || cnt_in == '0);
         end
      end else begin
         last = 1'b1;
      end

      if (last) begin
         feed_in = '0;
         if (job.last) amp_in = 1'b0;
      end
   end

   // carriage-return drop and newline collapse
   assign emit = cand_v && cand != hte_pkg::CH_CR && !(cand == hte_pkg::CH_LF && prev_nl_ff);

   always_comb begin
      prev_nl_in = prev_nl_ff;
      if (cand_v && cand != hte_pkg::CH_CR) prev_nl_in = cand == hte_pkg::CH_LF;
      if (last && job.last) prev_nl_in = 1'b0;

      push       = 1'b0;
      push_byte  = cand;
      push_empty = 1'b0;
      push_rl    = last;
      push_td    = last && job.last;
      set_flags  = 1'b0;
      if (step) begin
         if (emit) begin
            push = 1'b1;
         end else if (last && pend_v_ff && !pend_rl_ff) begin
            set_flags = 1'b1;
         end else if (last && job.last) begin
            push       = 1'b1;
            push_byte  = '0;
            push_empty = 1'b1;
         end
      end
      move = pend_v_ff && out_free && (pend_rl_ff || push);
   end

   assign job_pop = step && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         amp_ff     <= 1'b0;
         prev_nl_ff <= 1'b0;
         feed_ff    <= '0;
         flush_ff   <= 1'b0;
         fl_ff      <= '0;
         pend_v_ff  <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         if (step) begin
            cnt_ff     <= cnt_in;
            amp_ff     <= amp_in;
            prev_nl_ff <= prev_nl_in;
            feed_ff    <= feed_in;
            flush_ff   <= flush_in;
            fl_ff      <= fl_in;
         end
         if (push) pend_v_ff <= 1'b1;
         else if (move) pend_v_ff <= 1'b0;
         if (move) rsp_v_ff <= 1'b1;
         else if (rsp.ready) rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) hold_ff <= hold_in;
      if (push) begin
         pend_byte_ff  <= push_byte;
         pend_empty_ff <= push_empty;
         pend_rl_ff    <= push_rl;
         pend_td_ff    <= push_td;
      end else if (set_flags) begin
         pend_rl_ff <= 1'b1;
         pend_td_ff <= job.last;
      end
      if (move) begin
         rsp_byte_ff  <= pend_byte_ff;
         rsp_empty_ff <= pend_empty_ff;
         rsp_rl_ff    <= pend_rl_ff;
         rsp_td_ff    <= pend_td_ff;
      end
   end

   assign rsp.valid     = rsp_v_ff;
   assign rsp.out_byte  = rsp_byte_ff;
   assign rsp.out_empty = rsp_empty_ff;
   assign rsp.run_last  = rsp_rl_ff;
   assign rsp.text_done = rsp_td_ff;

endmodule

/* hw/rtl/html_text_extractor_top.sv */
// Channel   Dir  Payload                                     Transfer
// req_chan  in   in_byte[7:0], end_of_text                   valid & ready
// rsp_chan  out  out_byte[7:0], out_empty, run_last,         valid & ready
//                text_done
//
// Front parses tags at one byte per cycle while the queue has room and queues
// one job per byte (4 deep). Back runs the entity decoder, one result per cycle
// while the output is free; an li bullet feeds six bytes, a broken entity spills
// its held bytes. Each result waits in a pending register until run_last is known.
// Reset is synchronous; it clears all control state, no clearing pass.
// Either side may stall; the queue and the output register decouple them.
module html_text_extractor_top (
   input  logic       clock,
   input  logic       reset,
   hte_req_if.sink    req_chan,
   hte_rsp_if.source  rsp_chan
);

   hte_pkg::job_type  front_job, back_job;
   logic              front_valid, front_ready;
   logic              back_valid, back_pop;

   // tag parser and region tracker
   hte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_byte   (req_chan.in_byte),
      .in_end    (req_chan.end_of_text),
      .job_ready (front_ready),
      .job_valid (front_valid),
      .job       (front_job)
   );

   assign req_chan.ready = front_ready;

   // short job queue between parser and decoder
   hte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop        (back_pop),
      .pop_job    (back_job)
   );

   // entity decoder, newline filter and result framing
   hte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job       (back_job),
      .job_pop   (back_pop),
      .rsp       (rsp_chan)
   );

endmodule
